>>> rtl/cem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cem_pkg
// Shared types and codes of the client event mailbox.
// ----------------------------------------------------------------------------
package cem_pkg;

    localparam logic [31:0] FREE_ID   = 32'hFFFF_FFFF;
    localparam int          RES_DEPTH = 4;

    // request type codes as seen on the input port
    localparam logic [2:0] REQ_REGISTER   = 3'd0;
    localparam logic [2:0] REQ_UNREGISTER = 3'd1;
    localparam logic [2:0] REQ_POST       = 3'd2;
    localparam logic [2:0] REQ_POP        = 3'd3;
    localparam logic [2:0] REQ_QUERY      = 3'd4;
    localparam logic [2:0] REQ_SET_ICON   = 3'd5;
    // unassigned codes, answered with a failed status
    localparam logic [2:0] REQ_RSVD6      = 3'd6;
    localparam logic [2:0] REQ_RSVD7      = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_CONNECTED    = 2'd0;
    localparam logic [1:0] CFG_DISCONNECTED = 2'd1;
    localparam logic [1:0] CFG_NEW_ICON     = 2'd2;
    localparam logic [1:0] CFG_NO_ICON      = 2'd3;

    typedef enum logic [2:0] {
        OP_REG   = 3'd0,
        OP_UNREG = 3'd1,
        OP_POST  = 3'd2,
        OP_POP   = 3'd3,
        OP_QUERY = 3'd4,
        OP_ICON  = 3'd5,
        OP_BAD   = 3'd7
    } t_op;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [31:0]        client_id;
        logic [31:0]        notify_tag;
        logic               is_dock;
        logic               skip_dock;
        logic [31:0]        ev_code;
        logic [31:0]        obj_code;
        logic signed [31:0] icon_id;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic        ok;
        logic [31:0] signal_tag;
        logic [31:0] popped_event;
        logic [31:0] popped_object;
        logic        last;
    } t_res;

    // classified request handed from front to back
    typedef struct packed {
        t_op                op;
        logic               id_ok;
        logic [31:0]        client_id;
        logic [31:0]        notify_tag;
        logic               is_dock;
        logic               skip_dock;
        logic [31:0]        ev_code;
        logic [31:0]        obj_code;
        logic signed [31:0] icon_id;
    } t_cmd;

endpackage

>>> rtl/cem_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cem_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/cem_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cem_front
// Accepts request items, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cem_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cem_pkg::t_req  i_req,
    output logic           o_full,
    output cem_pkg::t_cmd  o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_take
);
    import cem_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       acc;

    always_comb begin
        dec = '0;
        unique case (i_req.req_type)
            REQ_REGISTER:   dec.op = OP_REG;
            REQ_UNREGISTER: dec.op = OP_UNREG;
            REQ_POST:       dec.op = OP_POST;
            REQ_POP:        dec.op = OP_POP;
            REQ_QUERY:      dec.op = OP_QUERY;
            REQ_SET_ICON:   dec.op = OP_ICON;
            default:        dec.op = OP_BAD;
        endcase
        dec.id_ok      = (i_req.client_id != FREE_ID);
        dec.client_id  = i_req.client_id;
        dec.notify_tag = i_req.notify_tag;
        dec.is_dock    = i_req.is_dock;
        dec.skip_dock  = i_req.skip_dock;
        dec.ev_code    = i_req.ev_code;
        dec.obj_code   = i_req.obj_code;
        dec.icon_id    = i_req.icon_id;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign acc         = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(acc) - 2'(i_cmd_take);
        end
    end
endmodule

>>> rtl/cem_rfifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cem_rfifo
// Small result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module cem_rfifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  cem_pkg::t_res i_data,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output cem_pkg::t_res o_data
);
    import cem_pkg::*;

    localparam int PW = $clog2(RES_DEPTH);

    t_res        r_q [RES_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          rd;

    assign o_full  = (r_cnt == (PW+1)'(RES_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(i_wr) - (PW+1)'(rd);
        end
    end
endmodule

>>> rtl/cem_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cem_back
// Executes requests against the slot table and the event store.
// ----------------------------------------------------------------------------
module cem_back #(
    parameter int NUM_SLOTS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  cem_pkg::t_cmd   i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_take,
    output logic            o_res_wr,
    output cem_pkg::t_res   o_res,
    input  logic            i_res_full
);
    import cem_pkg::*;

    localparam int SW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int MEMD = NUM_SLOTS * QUEUE_DEPTH;
    localparam int AW   = $clog2(MEMD);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_BCAST  = 4'b0100,
        S_STATUS = 4'b1000
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic          r_ok, r_pop_hit;
    logic [31:0]   r_code;
    logic [SW-1:0] r_target, r_scan;
    logic [31:0]   r_conn, r_disc, r_newicon, r_noicon;

    logic [31:0]   r_owner [NUM_SLOTS];
    logic          r_dock  [NUM_SLOTS];
    logic [31:0]   r_tag   [NUM_SLOTS];
    logic [31:0]   r_icon  [NUM_SLOTS];
    logic [FW-1:0] r_fill  [NUM_SLOTS];
    logic [HW-1:0] r_head  [NUM_SLOTS];

    logic          hit, free_any;
    logic [SW-1:0] hit_idx, free_idx, wslot;
    logic          hit_space, hit_nonempty, bc_en;
    logic          post_go, bc_go, bc_step, pop_go, st_go;
    logic [FW:0]   wsum;
    logic [HW-1:0] widx;
    logic          ram_we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   rdata;

    // parallel lookup, lowest slot wins
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_cmd.id_ok && r_owner[s] == r_cmd.client_id) begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
            if (r_owner[s] == FREE_ID) begin
                free_any = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    assign hit_space    = r_fill[hit_idx] < FW'(QUEUE_DEPTH);
    assign hit_nonempty = r_fill[hit_idx] != '0;
    assign bc_en        = (r_owner[r_scan] != FREE_ID) && r_dock[r_scan]
                          && (r_fill[r_scan] < FW'(QUEUE_DEPTH));

    assign post_go = (r_state == S_EXEC) && (r_cmd.op == OP_POST) && hit && hit_space
                     && !i_res_full;
    assign pop_go  = (r_state == S_EXEC) && (r_cmd.op == OP_POP) && hit && hit_nonempty;
    assign bc_go   = (r_state == S_BCAST) && bc_en && !i_res_full;
    assign bc_step = (r_state == S_BCAST) && (!bc_en || !i_res_full);
    assign st_go   = (r_state == S_STATUS) && !i_res_full;

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;

    // tail index of the written slot's ring
    assign wslot = (r_state == S_EXEC) ? hit_idx : r_scan;
    assign wsum  = (FW+1)'(r_head[wslot]) + (FW+1)'(r_fill[wslot]);
    assign widx  = (wsum >= (FW+1)'(QUEUE_DEPTH)) ? HW'(wsum - (FW+1)'(QUEUE_DEPTH))
                                                   : HW'(wsum);
    assign ram_we = post_go || bc_go;
    assign waddr  = AW'(wslot) * AW'(QUEUE_DEPTH) + AW'(widx);
    assign raddr  = AW'(hit_idx) * AW'(QUEUE_DEPTH) + AW'(r_head[hit_idx]);

    cem_ram #(.WIDTH(64), .DEPTH(MEMD)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (post_go ? {r_cmd.ev_code, r_cmd.obj_code}
                          : {r_code, 32'(r_target)}),
        .i_re    (pop_go),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_res    = '0;
        o_res_wr = post_go || bc_go || st_go;
        if (st_go) begin
            o_res.ok   = r_ok;
            o_res.last = 1'b1;
            if (r_pop_hit) begin
                o_res.popped_event  = rdata[63:32];
                o_res.popped_object = rdata[31:0];
            end
        end else begin
            o_res.result_kind = 1'b1;
            o_res.ok          = 1'b1;
            o_res.signal_tag  = r_tag[wslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ok      <= 1'b0;
            r_pop_hit <= 1'b0;
            r_code    <= '0;
            r_target  <= '0;
            r_scan    <= '0;
            r_conn    <= 32'd0;
            r_disc    <= 32'd1;
            r_newicon <= 32'd2;
            r_noicon  <= 32'hFFFF_FFFF;
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_owner[s] <= FREE_ID;
                r_dock[s]  <= 1'b0;
                r_tag[s]   <= '0;
                r_icon[s]  <= 32'hFFFF_FFFF;
                r_fill[s]  <= '0;
                r_head[s]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CONNECTED:    r_conn    <= i_cfg_data;
                    CFG_DISCONNECTED: r_disc    <= i_cfg_data;
                    CFG_NEW_ICON:     r_newicon <= i_cfg_data;
                    CFG_NO_ICON:      r_noicon  <= i_cfg_data;
                    default:          r_conn    <= r_conn;
                endcase
            end
            if (ram_we) begin
                r_fill[wslot] <= r_fill[wslot] + FW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_ok      <= 1'b0;
                        r_pop_hit <= 1'b0;
                        r_scan    <= '0;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_cmd.op)
                        OP_REG: begin
                            if (r_cmd.id_ok && !hit && free_any) begin
                                r_owner[free_idx] <= r_cmd.client_id;
                                r_tag[free_idx]   <= r_cmd.notify_tag;
                                r_dock[free_idx]  <= r_cmd.is_dock;
                                r_fill[free_idx]  <= '0;
                                r_head[free_idx]  <= '0;
                                r_ok              <= 1'b1;
                                r_target          <= free_idx;
                                r_code            <= r_conn;
                                r_state <= r_cmd.skip_dock ? S_STATUS : S_BCAST;
                            end else begin
                                r_state <= S_STATUS;
                            end
                        end
                        OP_UNREG: begin
                            if (hit) begin
                                r_owner[hit_idx] <= FREE_ID;
                                r_tag[hit_idx]   <= '0;
                                r_dock[hit_idx]  <= 1'b0;
                                r_fill[hit_idx]  <= '0;
                                r_head[hit_idx]  <= '0;
                                r_icon[hit_idx]  <= r_noicon;
                                r_ok             <= 1'b1;
                                r_target         <= hit_idx;
                                r_code           <= r_disc;
                                r_state          <= S_BCAST;
                            end else begin
                                r_state <= S_STATUS;
                            end
                        end
                        OP_POST: begin
                            // wait for room for the notification
                            if (hit && hit_space && i_res_full) begin
                                r_state <= S_EXEC;
                            end else begin
                                r_state <= S_STATUS;
                            end
                            if (post_go) begin
                                r_ok <= 1'b1;
                            end
                        end
                        OP_POP: begin
                            r_state <= S_STATUS;
                            if (pop_go) begin
                                r_ok      <= 1'b1;
                                r_pop_hit <= 1'b1;
                                r_fill[hit_idx] <= r_fill[hit_idx] - FW'(1);
                                r_head[hit_idx] <=
                                    (r_head[hit_idx] == HW'(QUEUE_DEPTH - 1)) ? '0
                                    : r_head[hit_idx] + HW'(1);
                            end
                        end
                        OP_QUERY: begin
                            r_ok    <= hit;
                            r_state <= S_STATUS;
                        end
                        OP_ICON: begin
                            if (hit) begin
                                r_icon[hit_idx] <= r_cmd.icon_id;
                                r_ok            <= 1'b1;
                                r_target        <= hit_idx;
                                r_code          <= r_newicon;
                                r_state         <= S_BCAST;
                            end else begin
                                r_state <= S_STATUS;
                            end
                        end
                        default: begin
                            r_ok    <= 1'b0;
                            r_state <= S_STATUS;
                        end
                    endcase
                end
                S_BCAST: begin
                    if (bc_step) begin
                        r_scan <= r_scan + SW'(1);
                        if (r_scan == SW'(NUM_SLOTS - 1)) begin
                            r_state <= S_STATUS;
                        end
                    end
                end
                S_STATUS: begin
                    if (st_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/client_event_mailbox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_event_mailbox
// Client slot table with per-client event queues and dock broadcasts.
// ----------------------------------------------------------------------------
//
//  channel   | ports                               | item
//  ----------+-------------------------------------+----------------------------
//  request   | i_push, o_full, i_req               | one request (t_req)
//  result    | o_empty, i_pop, o_res               | status or notification (t_res)
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data     | one 32-bit register write
//
//  Sequence: the back end picks up a query, post or pop, executes it and then
//  writes its status. A register, unregister or set icon that succeeds and is
//  announced also scans every slot for docks between execute and status.
//  Reset: synchronous, active low; all slots free, queues empty, codes at
//  their defaults. The event store needs no clearing.
//  Stalls: a two-entry request queue takes items while the back end works; the
//  back end holds while a result it must write meets a full result queue.
// ----------------------------------------------------------------------------
module client_event_mailbox #(
    parameter int NUM_SLOTS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  cem_pkg::t_req i_req,
    output logic          o_empty,
    input  logic          i_pop,
    output cem_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import cem_pkg::*;

    t_cmd    cmd;
    logic    cmd_valid, cmd_take;
    t_res    res_data;
    logic    res_wr, res_full;

    // front: decode and buffer requests
    cem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_req       (i_req),
        .o_full      (o_full),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take)
    );

    // back: slot table, event store, broadcast scan
    cem_back #(
        .NUM_SLOTS   (NUM_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .o_res_wr    (res_wr),
        .o_res       (res_data),
        .i_res_full  (res_full)
    );

    // results wait here until popped
    cem_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_data  (res_data),
        .o_full  (res_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_res)
    );

    // back end never writes into a full result queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> !res_full) else $error("result queue overrun");

    // a final result is always a status, a notification never is final
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> (res_data.last != res_data.result_kind))
        else $error("bad result kind/last pairing");

    // after reset both queues are empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full)) else $error("queues not empty after reset");

    // a command is taken only when one is waiting
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid) else $error("command taken from empty queue");
endmodule
